>>> design/sorted_priority_queue_top_macros.svh
// assertion macros shared by the sorted priority queue modules
// expects clk_i and rst_ni in the scope of each use
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/spq_pkg.sv
// types, constants and helpers of the sorted priority queue
// used by spq_datapath, spq_ctrl and sorted_priority_queue_top
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  // operation codes carried in tuser
  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
  localparam logic [1:0] FUNC_REMOVE  = 2'd2;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_INSERT,
    DP_DEQUEUE,
    DP_NOP,
    DP_RM_LOAD,
    DP_RM_STEP,
    DP_RM_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic rm_hit;
  } dp_status_t;

  typedef struct packed {
    logic [15:0]              id;
    logic [PRIORITY_BITS-1:0] prio;
  } slot_t;

  typedef struct packed {
    logic [4:0]  fill_count;
    logic        is_empty;
    logic        overflow;
    logic        found;
    logic [7:0]  out_priority;
    logic [15:0] out_id;
    logic        out_valid;
  } result_t;

  function automatic logic [PRIORITY_BITS-1:0] to_prio(logic [7:0] p);
    logic [PRIORITY_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < PRIORITY_BITS && i < 8; i++) begin
      r[i] = p[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] from_prio(logic [PRIORITY_BITS-1:0] p);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < PRIORITY_BITS && i < 8; i++) begin
      r[i] = p[i];
    end
    return r;
  endfunction

endpackage

>>> design/sorted_priority_queue_top.sv
// channel    | dir | tdata bits (low first)                                  | tuser
// s_axis     | in  | entry_id[15:0], entry_priority[23:16]                   | func[1:0]
// m_axis     | out | out_valid, out_id, out_priority, found, overflow,       | -
//            |     | is_empty, fill_count[32:28], zero fill to 40 bits       |
// insert, dequeue, unused code: the taking edge stages the result and any queue update,
// the result moves to the m_axis register once free; only then is the next item taken
// remove: load the id, take out matching entries one by one, a closing step, a move out
// reset clears the entry count and handshake state; the slot array keeps no reset
// one result can sit staged behind the output register, so an item is taken while
// a result waits downstream; a second result waiting holds off the input
`timescale 1ns / 1ps

module sorted_priority_queue_top import spq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // entry_id, entry_priority
  input  logic [1:0]  s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // out_valid, out_id, out_priority, found,
                                        // overflow, is_empty, fill_count
);

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_func_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_id_i   (s_axis_tdata_i[15:0]),
    .in_prio_i (s_axis_tdata_i[23:16]),
    .status_o  (status),
    .out_o     (result)
  );

  assign m_axis_tdata_o = {7'd0, result};

endmodule

>>> design/spq_datapath.sv
// slot array, compare network and result registers of the priority queue
// depends on spq_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sorted_priority_queue_top_macros.svh"

module spq_datapath import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  logic [15:0] in_id_i,
  input  logic [7:0]  in_prio_i,
  output dp_status_t status_o,
  output result_t    out_o
);

  slot_t slot_q [QUEUE_DEPTH];
  slot_t slot_d [QUEUE_DEPTH];
  slot_t shift_up [QUEUE_DEPTH];
  slot_t shift_dn [QUEUE_DEPTH];

  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      rm_id_q, rm_id_d;
  logic             found_q, found_d;
  result_t          res_q, res_d;
  result_t          out_q;

  logic [QUEUE_DEPTH-1:0] valid, lt, lt_prev, match, first, above;
  logic                   full, sorted_ok, res_ld;
  logic                   ins_ok, step_cmd;
  slot_t                  new_slot;

  assign new_slot.id   = in_id_i;
  assign new_slot.prio = to_prio(in_prio_i);
  assign full          = (count_q == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      valid[k] = (CNT_W'(k) < count_q);
      lt[k]    = valid[k] && (slot_q[k].prio < new_slot.prio);
      match[k] = valid[k] && (slot_q[k].id == rm_id_q);
    end
    lt_prev[0]  = 1'b0;
    shift_up[0] = new_slot;
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      lt_prev[k]  = lt[k-1];
      shift_up[k] = slot_q[k-1];
    end
    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
      shift_dn[k] = slot_q[k+1];
    end
    shift_dn[QUEUE_DEPTH-1] = slot_q[QUEUE_DEPTH-1];
  end

  // lowest matching slot and every slot at or above it
  assign first = match & (~match + 1'b1);
  assign above = ~(first - 1'b1);

  assign status_o.rm_hit = |match;

  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    rm_id_d = rm_id_q;
    found_d = found_q;
    res_d   = '0;
    res_ld  = 1'b0;
    unique case (cmd_i.op)
      DP_INSERT: begin
        res_ld = 1'b1;
        if (full) begin
          res_d.overflow = 1'b1;
        end else begin
          for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (!lt[k]) begin
              slot_d[k] = lt_prev[k] || (k == 0) ? new_slot : shift_up[k];
            end
          end
          count_d = count_q + CNT_W'(1);
        end
      end
      DP_DEQUEUE: begin
        res_ld = 1'b1;
        if (count_q != '0) begin
          res_d.out_valid    = 1'b1;
          res_d.out_id       = slot_q[0].id;
          res_d.out_priority = from_prio(slot_q[0].prio);
          slot_d             = shift_dn;
          count_d            = count_q - CNT_W'(1);
        end
      end
      DP_NOP: begin
        res_ld = 1'b1;
      end
      DP_RM_LOAD: begin
        rm_id_d = in_id_i;
        found_d = 1'b0;
      end
      DP_RM_STEP: begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
          if (above[k]) begin
            slot_d[k] = shift_dn[k];
          end
        end
        count_d = count_q - CNT_W'(1);
        found_d = 1'b1;
      end
      DP_RM_DONE: begin
        res_ld      = 1'b1;
        res_d.found = found_q;
      end
      default: begin
      end
    endcase
    res_d.is_empty   = (count_d == '0);
    res_d.fill_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    rm_id_q <= rm_id_d;
    found_q <= found_d;
    if (res_ld) begin
      res_q <= res_d;
    end
    if (cmd_i.out_ld) begin
      out_q <= res_q;
    end
  end

  assign out_o = out_q;

  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 1; k < QUEUE_DEPTH; k++) begin
      if (valid[k] && (slot_q[k].prio < slot_q[k-1].prio)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  assign ins_ok   = (cmd_i.op == DP_INSERT) && !full;
  assign step_cmd = (cmd_i.op == DP_RM_STEP);

  `SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `SPQ_ASSERT(a_sorted, sorted_ok, "stored entries out of priority order")
  `SPQ_ASSERT(a_insert_grows, ins_ok |=> (count_q == $past(count_q) + 1'b1), "insert lost")
  `SPQ_ASSERT(a_step_has_hit, step_cmd |-> status_o.rm_hit, "remove step without a match")

endmodule

>>> design/spq_ctrl.sv
// control state machine of the priority queue: handshakes and datapath commands
// depends on spq_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sorted_priority_queue_top_macros.svh"

module spq_ctrl import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_func_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_REMOVE = 1'b1;

  logic state_q, state_d;
  logic res_valid_q, res_valid_d;
  logic out_valid_q, out_valid_d;
  logic accept, res_ld, out_ld, rm_start;

  assign in_ready_o = (state_q == ST_IDLE) && !res_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign rm_start   = accept && (in_func_i == FUNC_REMOVE);

  // staged result moves on whenever the output register is free or draining
  assign out_ld = res_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = DP_IDLE;
    cmd_o.out_ld = out_ld;
    res_ld       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func_i)
            FUNC_INSERT: begin
              cmd_o.op = DP_INSERT;
              res_ld   = 1'b1;
            end
            FUNC_DEQUEUE: begin
              cmd_o.op = DP_DEQUEUE;
              res_ld   = 1'b1;
            end
            FUNC_REMOVE: begin
              cmd_o.op = DP_RM_LOAD;
              state_d  = ST_REMOVE;
            end
            default: begin
              cmd_o.op = DP_NOP;
              res_ld   = 1'b1;
            end
          endcase
        end
      end
      ST_REMOVE: begin
        // one matching entry leaves per cycle
        if (status_i.rm_hit) begin
          cmd_o.op = DP_RM_STEP;
        end else begin
          cmd_o.op = DP_RM_DONE;
          res_ld   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_ld) begin
      res_valid_d = 1'b1;
    end else if (out_ld) begin
      res_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SPQ_ASSERT(a_accept_stage_free, accept |-> !res_valid_q, "item taken while result staged")
  `SPQ_ASSERT(a_remove_enters, rm_start |=> (state_q == ST_REMOVE), "remove sweep not started")
  `SPQ_ASSERT(a_remove_stage_empty, (state_q == ST_REMOVE) |-> !res_valid_q, "staged in sweep")

endmodule
